@@ src/obrb_pkg.sv @@
// shared types and constants for the overwriting byte ring buffer
// no dependencies; imported by every module of the block

package obrb_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUT         = 2'd0,
        CMD_GET         = 2'd1,
        CMD_FLUSH       = 2'd2,
        CMD_FLUSH_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic [7:0]       front_byte;
        logic [CNT_W-1:0] fill_count;
        logic             overwrote;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

@@ src/overwriting_byte_ring_buffer.sv @@
// overwriting byte ring buffer: one command in, one result word out
// the accepting edge registers the command and the read of the byte store, then the execute
// state registers the result and the o_done strobe; start is ignored while busy is high
// a new command may be accepted in the cycle o_done is shown
// synchronous active-low reset empties the buffer and marks every entry as zero
// depends on obrb_pkg, obrb_ctrl, obrb_dp

module overwriting_byte_ring_buffer import obrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_done,
    output t_out o_res
);

    t_ctrl ctrl;

    obrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    obrb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_in    (i_in),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

@@ src/obrb_ctrl.sv @@
// controller for the ring buffer: idle/execute sequencing and busy flag
// depends on obrb_pkg

module obrb_ctrl import obrb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.load = i_start && (r_state == S_IDLE);
    assign o_ctrl.exec = (r_state == S_EXEC);

endmodule

@@ src/obrb_dp.sv @@
// datapath for the ring buffer: byte store, valid bits, pointers, count, result
// depends on obrb_pkg

module obrb_dp import obrb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_in   i_in,
    output logic  o_done,
    output t_out  o_res
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    t_in        r_item;
    logic [7:0] r_rdata;
    logic       r_rvalid;
    logic       r_done;
    t_out       r_res;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_cnt;
    logic             n_wr_en;
    logic             n_clear;
    t_out             n_res;
    logic [7:0]       front;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    // entries never written since reset or clear read as zero
    assign front = r_rvalid ? r_rdata : 8'h00;

    always_comb begin
        n_wr_ptr         = r_wr_ptr;
        n_rd_ptr         = r_rd_ptr;
        n_cnt            = r_cnt;
        n_wr_en          = 1'b0;
        n_clear          = 1'b0;
        n_res.read_byte  = 8'h00;
        n_res.front_byte = front;
        n_res.overwrote  = 1'b0;
        case (r_item.cmd)
            CMD_PUT: begin
                n_wr_en  = 1'b1;
                n_wr_ptr = ptr_next(r_wr_ptr);
                if (r_cnt != CNT_W'(DEPTH)) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    // full: drop the oldest word
                    n_rd_ptr        = ptr_next(r_rd_ptr);
                    n_res.overwrote = 1'b1;
                end
            end
            CMD_GET: begin
                if (r_cnt != '0) begin
                    n_res.read_byte = front;
                    n_rd_ptr        = ptr_next(r_rd_ptr);
                    n_cnt           = r_cnt - 1'b1;
                end
            end
            CMD_FLUSH: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_cnt    = '0;
            end
            CMD_FLUSH_CLEAR: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_cnt    = '0;
                n_clear  = 1'b1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        n_res.fill_count = n_cnt;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_ctrl.exec;
            if (i_ctrl.exec) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
                r_cnt    <= n_cnt;
                if (n_clear) begin
                    r_vld <= '0;
                end else if (n_wr_en) begin
                    r_vld[r_wr_ptr] <= 1'b1;
                end
            end
        end
    end

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && n_wr_en) begin
            r_mem[r_wr_ptr] <= r_item.data_byte;
        end
        if (i_ctrl.load) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item   <= i_in;
            r_rvalid <= r_vld[r_rd_ptr];
        end
        if (i_ctrl.exec) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ src/obrb_checker.sv @@
// port-level checker for the overwriting byte ring buffer, bound to the top level
// depends on obrb_pkg and overwriting_byte_ring_buffer

module obrb_checker import obrb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_out o_res
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_done)
        else $error("execute cycle not followed by a result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_done)
        else $error("result strobe without a command");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.fill_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_overwrite_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.overwrote |-> o_res.fill_count == CNT_W'(DEPTH)
            && o_res.read_byte == 8'h00)
        else $error("overwrite reported while not full");

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
